[design/igbs_pkg.sv]
`timescale 1ns / 1ps

package igbs_pkg;

    // Count width and feature range
    localparam int COUNT_BITS   = 16;
    localparam int MAX_FEATURES = 64;
    localparam int IDX_W        = 6;
    localparam int GAIN_W       = 32;
    localparam int FRAC_BITS    = 30;

    // Shared divider: dividend holds count << 30 or count * entropy
    localparam int DIV_W     = COUNT_BITS + 32;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    // log2 result Q6.30, entropy accumulator, subtrahend sum
    localparam int LOG_W     = 36;
    localparam int LOG_ITERS = FRAC_BITS;
    localparam int IT_W      = $clog2(LOG_ITERS);
    localparam int H_W       = 36;
    localparam int SUB_W     = DIV_W + 1;
    localparam int N_TERMS   = 6;
    localparam int TERM_W    = 3;
    localparam logic [TERM_W-1:0] LAST_TERM = TERM_W'(N_TERMS - 1);

    // Stream widths, padded to whole bytes
    localparam int IN_DATA_W  = ((IDX_W + 9 * COUNT_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((IDX_W + GAIN_W + 7) / 8) * 8;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_TERM,
        S_DIV_WAIT,
        S_LOG_INIT,
        S_LOG_ITER,
        S_MUL_INT,
        S_MUL_FRAC,
        S_NEXT,
        S_WMUL,
        S_WDIV_START,
        S_WDIV_WAIT,
        S_ADV,
        S_DONE
    } t_state;

    // Clamped counts: yes/no per set (parent, left, right), and set totals
    typedef struct packed {
        logic [N_TERMS-1:0][COUNT_BITS-1:0] cnt;
        logic [2:0][COUNT_BITS-1:0]         tot;
    } t_item;

    // Parent entropy and sum of weighted branch entropies
    typedef struct packed {
        logic [31:0]      hp;
        logic [SUB_W-1:0] sub;
    } t_core_res;

endpackage

[design/igbs_div.sv]
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle
module igbs_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [igbs_pkg::DIV_W-1:0]       i_dividend,
    input  logic [igbs_pkg::COUNT_BITS-1:0]  i_divisor,
    output logic                             o_done,
    output logic [igbs_pkg::DIV_W-1:0]       o_quotient
);

    logic [igbs_pkg::DIV_W-1:0]      r_q;
    logic [igbs_pkg::COUNT_BITS-1:0] r_rem;
    logic [igbs_pkg::COUNT_BITS-1:0] r_div;
    logic [igbs_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic                            r_run;
    logic                            r_done;
    logic [igbs_pkg::COUNT_BITS:0]   rem_sh;
    logic [igbs_pkg::COUNT_BITS:0]   rem_diff;
    logic                            ge;

    // Trial subtract
    always_comb begin
        rem_sh   = {r_rem, r_q[igbs_pkg::DIV_W-1]};
        rem_diff = rem_sh - {1'b0, r_div};
        ge       = rem_sh >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q   <= i_dividend;
                r_rem <= '0;
                r_div <= i_divisor;
                r_cnt <= igbs_pkg::DIV_CNT_W'(igbs_pkg::DIV_W);
                r_run <= 1'b1;
            end else if (r_run) begin
                r_rem <= ge ? rem_diff[igbs_pkg::COUNT_BITS-1:0]
                            : rem_sh[igbs_pkg::COUNT_BITS-1:0];
                r_q   <= {r_q[igbs_pkg::DIV_W-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == igbs_pkg::DIV_CNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

[design/igbs_seq.sv]
`timescale 1ns / 1ps

// Entropy sequencer: one shared 32x32 multiplier, one shared divider
module igbs_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  igbs_pkg::t_item      i_item,
    output logic                 o_done,
    output igbs_pkg::t_core_res  o_res
);

    igbs_pkg::t_state r_state, n_state;

    logic [igbs_pkg::TERM_W-1:0]    r_term;
    logic                           r_sel;
    logic [igbs_pkg::IT_W-1:0]      r_it;
    logic [31:0]                    r_m;
    logic [4:0]                     r_k;
    logic [igbs_pkg::FRAC_BITS-1:0] r_frac;
    logic [30:0]                    r_p;
    logic [igbs_pkg::LOG_W-1:0]     r_lt;
    logic [igbs_pkg::LOG_W-1:0]     r_lc;
    logic [igbs_pkg::H_W-1:0]       r_h;
    logic [31:0]                    r_hp;
    logic [igbs_pkg::SUB_W-1:0]     r_sub;
    logic [igbs_pkg::DIV_W-1:0]     r_wprod;

    logic [igbs_pkg::COUNT_BITS-1:0] cur_c;
    logic [igbs_pkg::COUNT_BITS-1:0] cur_t;
    logic [igbs_pkg::COUNT_BITS-1:0] log_x;
    logic                            skip;
    logic [4:0]                      k;
    logic [31:0]                     m0;
    logic [igbs_pkg::LOG_W-1:0]      d;
    logic [igbs_pkg::LOG_W-1:0]      log_val;
    logic [31:0]                     mul_a;
    logic [31:0]                     mul_b;
    logic [63:0]                     prod;
    logic [32:0]                     sq_s;
    logic                            div_start;
    logic [igbs_pkg::DIV_W-1:0]      div_dividend;
    logic [igbs_pkg::COUNT_BITS-1:0] div_divisor;
    logic                            div_done;
    logic [igbs_pkg::DIV_W-1:0]      div_q;

    // Operand selection for the current term
    always_comb begin
        cur_c = i_item.cnt[r_term];
        cur_t = i_item.tot[r_term[2:1]];
        skip  = (cur_c == '0) || (cur_t == '0);
        log_x = r_sel ? cur_c : cur_t;
    end

    // Leading one and normalised mantissa for log2
    always_comb begin
        k = '0;
        for (int i = 0; i < igbs_pkg::COUNT_BITS; i++) begin
            if (log_x[i]) k = 5'(i);
        end
        m0 = 32'(log_x) << (5'd31 - k);
    end

    // Log difference, clipped at zero
    always_comb begin
        d = (r_lt > r_lc) ? (r_lt - r_lc) : '0;
    end

    // Shared multiplier
    assign prod    = mul_a * mul_b;
    assign sq_s    = prod[63:31];
    assign log_val = {1'b0, r_k, r_frac[igbs_pkg::FRAC_BITS-2:0], sq_s[32]};

    igbs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            igbs_pkg::S_IDLE:       if (i_start) n_state = igbs_pkg::S_TERM;
            igbs_pkg::S_TERM:       n_state = skip ? igbs_pkg::S_NEXT : igbs_pkg::S_DIV_WAIT;
            igbs_pkg::S_DIV_WAIT:   if (div_done) n_state = igbs_pkg::S_LOG_INIT;
            igbs_pkg::S_LOG_INIT:   n_state = igbs_pkg::S_LOG_ITER;
            igbs_pkg::S_LOG_ITER: begin
                if (r_it == igbs_pkg::IT_W'(igbs_pkg::LOG_ITERS - 1))
                    n_state = r_sel ? igbs_pkg::S_MUL_INT : igbs_pkg::S_LOG_INIT;
            end
            igbs_pkg::S_MUL_INT:    n_state = igbs_pkg::S_MUL_FRAC;
            igbs_pkg::S_MUL_FRAC:   n_state = igbs_pkg::S_NEXT;
            igbs_pkg::S_NEXT: begin
                if (!r_term[0] || r_term == igbs_pkg::TERM_W'(1))
                    n_state = igbs_pkg::S_TERM;
                else if (i_item.tot[0] == '0)
                    n_state = igbs_pkg::S_ADV;
                else
                    n_state = igbs_pkg::S_WMUL;
            end
            igbs_pkg::S_WMUL:       n_state = igbs_pkg::S_WDIV_START;
            igbs_pkg::S_WDIV_START: n_state = igbs_pkg::S_WDIV_WAIT;
            igbs_pkg::S_WDIV_WAIT:  if (div_done) n_state = igbs_pkg::S_ADV;
            igbs_pkg::S_ADV: begin
                n_state = (r_term == igbs_pkg::LAST_TERM) ? igbs_pkg::S_DONE
                                                           : igbs_pkg::S_TERM;
            end
            igbs_pkg::S_DONE:       n_state = igbs_pkg::S_IDLE;
            default:                n_state = igbs_pkg::S_IDLE;
        endcase
    end

    // Unit control per state
    always_comb begin
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        div_dividend = igbs_pkg::DIV_W'(cur_c) << igbs_pkg::FRAC_BITS;
        div_divisor  = cur_t;
        o_done       = 1'b0;
        unique case (r_state)
            igbs_pkg::S_TERM:       div_start = !skip;
            igbs_pkg::S_LOG_ITER: begin
                mul_a = r_m;
                mul_b = r_m;
            end
            igbs_pkg::S_MUL_INT: begin
                mul_a = {1'b0, r_p};
                mul_b = 32'(d[igbs_pkg::LOG_W-1:igbs_pkg::FRAC_BITS]);
            end
            igbs_pkg::S_MUL_FRAC: begin
                mul_a = {1'b0, r_p};
                mul_b = 32'(d[igbs_pkg::FRAC_BITS-1:0]);
            end
            igbs_pkg::S_WMUL: begin
                mul_a = 32'(cur_t);
                mul_b = r_h[31:0];
            end
            // Weighted branch entropy is divided by the parent total
            igbs_pkg::S_WDIV_START: begin
                div_start    = 1'b1;
                div_dividend = r_wprod;
                div_divisor  = i_item.tot[0];
            end
            igbs_pkg::S_DONE:       o_done = 1'b1;
            default: ;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= igbs_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    // Counters and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term <= '0;
            r_sel  <= 1'b0;
            r_it   <= '0;
        end else begin
            unique case (r_state)
                igbs_pkg::S_IDLE: begin
                    if (i_start) begin
                        r_term <= '0;
                        r_h    <= '0;
                        r_sub  <= '0;
                    end
                end
                igbs_pkg::S_DIV_WAIT: begin
                    if (div_done) begin
                        r_p   <= div_q[30:0];
                        r_sel <= 1'b0;
                    end
                end
                igbs_pkg::S_LOG_INIT: begin
                    r_m    <= m0;
                    r_k    <= k;
                    r_it   <= '0;
                end
                igbs_pkg::S_LOG_ITER: begin
                    r_m    <= sq_s[32] ? sq_s[32:1] : sq_s[31:0];
                    r_frac <= {r_frac[igbs_pkg::FRAC_BITS-2:0], sq_s[32]};
                    r_it   <= r_it + 1'b1;
                    if (r_it == igbs_pkg::IT_W'(igbs_pkg::LOG_ITERS - 1)) begin
                        if (!r_sel) begin
                            r_lt  <= log_val;
                            r_sel <= 1'b1;
                        end else begin
                            r_lc  <= log_val;
                        end
                    end
                end
                igbs_pkg::S_MUL_INT:  r_h <= r_h + prod[igbs_pkg::H_W-1:0];
                igbs_pkg::S_MUL_FRAC: begin
                    r_h <= r_h + igbs_pkg::H_W'(prod[63:igbs_pkg::FRAC_BITS]);
                end
                igbs_pkg::S_NEXT: begin
                    if (!r_term[0]) begin
                        r_term <= r_term + 1'b1;
                    end else if (r_term == igbs_pkg::TERM_W'(1)) begin
                        r_hp   <= r_h[31:0];
                        r_h    <= '0;
                        r_term <= r_term + 1'b1;
                    end else if (i_item.tot[0] == '0) begin
                        r_h <= '0;
                    end
                end
                igbs_pkg::S_WMUL:     r_wprod <= prod[igbs_pkg::DIV_W-1:0];
                igbs_pkg::S_WDIV_WAIT: begin
                    if (div_done) begin
                        r_sub <= r_sub + igbs_pkg::SUB_W'(div_q);
                        r_h   <= '0;
                    end
                end
                igbs_pkg::S_ADV: begin
                    if (r_term != igbs_pkg::LAST_TERM) r_term <= r_term + 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_res.hp  = r_hp;
    assign o_res.sub = r_sub;

endmodule

[design/info_gain_best_split_unit.sv]
`timescale 1ns / 1ps

// ID3 best-split scorer. Each request carries one candidate feature's class
// counts; the unit computes parent entropy minus size-weighted branch
// entropies (signed Q2.30, saturated), keeps the best gain and its index
// (earliest wins ties) and returns one result on the request marked tlast.
// Class counts above their total are clamped and reported in m_axis_tuser.
// A request is taken only while idle and holds s_axis_tready low while it
// is scored: six entropy terms (a 48-bit division, two 30-step log2
// evaluations on the shared multiplier and two multiplies), two weighting
// steps (multiply plus division by the parent total), and the start and
// wrap-up steps. A term with a zero count or total skips its division, log2
// and multiplies; an empty parent skips the weighting.
// Non-last requests proceed while a result waits, but a request marked tlast
// is held until the previous result has been taken.
module info_gain_best_split_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // feature_index, parent_yes, parent_no, parent_total, left_yes, left_no,
    // left_total, right_yes, right_no, right_total, zero pad
    input  logic [igbs_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // considered
    input  logic                              s_axis_tuser,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // best_index, best_gain, zero pad
    output logic [igbs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // counts_error
    output logic                              m_axis_tuser
);

    localparam int CB = igbs_pkg::COUNT_BITS;

    logic                          r_busy;
    logic                          r_start;
    logic                          r_fin;
    igbs_pkg::t_item               r_item;
    logic [igbs_pkg::IDX_W-1:0]    r_idx;
    logic                          r_cons;
    logic                          r_last;
    igbs_pkg::t_core_res           r_res;
    logic                          r_err_seen;
    logic signed [31:0]            r_best_gain;
    logic [igbs_pkg::IDX_W-1:0]    r_best_idx;
    logic                          r_seen;
    logic                          r_out_valid;
    logic [igbs_pkg::IDX_W-1:0]    r_out_idx;
    logic [31:0]                   r_out_gain;
    logic                          r_out_err;

    logic                          accept;
    logic                          finalize;
    logic                          core_done;
    igbs_pkg::t_core_res           core_res;
    igbs_pkg::t_item               in_item;
    logic                          in_err;
    logic [8:0][CB-1:0]            raw;
    logic signed [igbs_pkg::SUB_W+1:0] diff;
    logic signed [31:0]            gain;
    logic                          take;
    logic signed [31:0]            new_gain;
    logic [igbs_pkg::IDX_W-1:0]    new_idx;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign finalize = r_fin && (!r_last || !r_out_valid);

    // Unpack and clamp counts
    always_comb begin
        for (int i = 0; i < 9; i++)
            raw[i] = s_axis_tdata[igbs_pkg::IDX_W + i*CB +: CB];
        in_err = 1'b0;
        for (int s = 0; s < 3; s++) begin
            in_item.tot[s] = raw[3*s+2];
            for (int j = 0; j < 2; j++) begin
                if (raw[3*s+j] > raw[3*s+2]) begin
                    in_item.cnt[2*s+j] = raw[3*s+2];
                    in_err             = 1'b1;
                end else begin
                    in_item.cnt[2*s+j] = raw[3*s+j];
                end
            end
        end
    end

    igbs_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_item  (r_item),
        .o_done  (core_done),
        .o_res   (core_res)
    );

    // Gain with saturation, best-so-far update
    always_comb begin
        diff = $signed({2'b00, r_res.hp}) - $signed({1'b0, r_res.sub});
        if (diff > $signed((igbs_pkg::SUB_W+2)'(32'sh7FFF_FFFF)))
            gain = 32'sh7FFF_FFFF;
        else if (diff < -$signed((igbs_pkg::SUB_W+2)'(33'sh0_8000_0000)))
            gain = 32'sh8000_0000;
        else
            gain = diff[31:0];
        if (!r_cons || ({26'd0, r_idx} >= 32'(igbs_pkg::MAX_FEATURES)))
            gain = '0;
        take     = !r_seen || (gain > r_best_gain);
        new_gain = take ? gain : r_best_gain;
        new_idx  = take ? r_idx : r_best_idx;
    end

    // Request intake and sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_start     <= 1'b0;
            r_fin       <= 1'b0;
            r_err_seen  <= 1'b0;
            r_seen      <= 1'b0;
            r_best_gain <= '0;
            r_best_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= accept;
            if (accept) begin
                r_busy     <= 1'b1;
                r_item     <= in_item;
                r_idx      <= s_axis_tdata[igbs_pkg::IDX_W-1:0];
                r_cons     <= s_axis_tuser;
                r_last     <= s_axis_tlast;
                r_err_seen <= r_err_seen | in_err;
            end
            if (core_done) begin
                r_fin <= 1'b1;
                r_res <= core_res;
            end
            if (m_axis_tready && r_out_valid) r_out_valid <= 1'b0;
            if (finalize) begin
                r_fin  <= 1'b0;
                r_busy <= 1'b0;
                if (r_last) begin
                    r_out_valid <= 1'b1;
                    r_out_idx   <= new_idx;
                    r_out_gain  <= new_gain;
                    r_out_err   <= r_err_seen;
                    r_best_gain <= '0;
                    r_best_idx  <= '0;
                    r_seen      <= 1'b0;
                    r_err_seen  <= 1'b0;
                end else begin
                    r_best_gain <= new_gain;
                    r_best_idx  <= new_idx;
                    r_seen      <= 1'b1;
                end
            end
        end
    end

    assign s_axis_tready = !r_busy;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = igbs_pkg::OUT_DATA_W'({r_out_gain, r_out_idx});
    assign m_axis_tuser  = r_out_err;

endmodule

[design/igbs_checker.sv]
`timescale 1ns / 1ps

// Port-level checks for the best-split unit
module igbs_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [igbs_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input logic                             m_axis_tuser
);

    // One request at a time: no intake right after a request
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("intake open right after a request");

    // Intake stays closed while scoring is under way
    a_busy_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |-> ##2 !s_axis_tready)
        else $error("request finished too early");

    // Reset empties the result register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind info_gain_best_split_unit igbs_checker u_igbs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

[verif/tb_info_gain_best_split_unit.sv]
`timescale 1ns / 1ps

module tb_info_gain_best_split_unit;

    localparam int  CYCLE_LIMIT = 4000000;
    localparam int  DRAIN_CYCLES = 1000;
    localparam int  N_RANDOM = 1200;
    localparam int  HOLD_CYCLES = 6000;

    // One candidate feature as carried by an input request
    typedef struct {
        logic [igbs_pkg::IDX_W-1:0]      fidx;
        logic                            considered;
        logic [igbs_pkg::COUNT_BITS-1:0] py, pn, pt, ly, ln, lt, ry, rn, rt;
        logic                            last;
    } t_feature;

    // One node verdict
    typedef struct {
        logic [igbs_pkg::IDX_W-1:0]  idx;
        logic [igbs_pkg::GAIN_W-1:0] gain;
        logic                        err;
    } t_verdict;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // feature_index, parent_yes/no/total, left_yes/no/total, right_yes/no/total, pad
    logic [igbs_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    // considered
    logic                  s_axis_tuser = 1'b0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // best_index, best_gain, pad
    logic [igbs_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    // counts_error
    logic                  m_axis_tuser;

    info_gain_best_split_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    // Predicted node state
    logic signed [31:0]         node_best_gain = '0;
    logic [igbs_pkg::IDX_W-1:0] node_best_idx = '0;
    logic                       node_seen = 1'b0;
    logic                       node_err = 1'b0;

    t_verdict verdict_q[$];
    int       n_fail = 0;
    int       n_cycles = 0;

    bit  tx_idle_en = 1'b1;
    bit  rx_idle_en = 1'b1;
    int  rx_gap = 0;
    int  rx_hold = 0;
    bit  hold_go = 1'b0;
    bit  hold_used = 1'b0;
    int  n_taken = 0;
    int  n_gapped = 0;
    bit  tx_started = 1'b0;

    // Fixed-point log2, unsigned Q6.30
    function automatic longint unsigned log2_q30(longint unsigned x);
        int k;
        longint unsigned m, fr;
        k = 31;
        fr = 0;
        while (k > 0 && x[k] == 1'b0) k--;
        m = x << (31 - k);
        for (int i = 0; i < igbs_pkg::FRAC_BITS; i++) begin
            m = (m * m) >> 31;
            if ((m >> 32) != 0) begin
                fr |= 64'd1 << (igbs_pkg::FRAC_BITS - 1 - i);
                m >>= 1;
            end
        end
        return (longint'(k) << igbs_pkg::FRAC_BITS) | fr;
    endfunction

    // p * log2(t/c) for one class
    function automatic longint unsigned class_term(longint unsigned c, longint unsigned t);
        longint unsigned p, lt, lc, d;
        if (c == 0 || t == 0) return 0;
        p = (c << igbs_pkg::FRAC_BITS) / t;
        lt = log2_q30(t);
        lc = log2_q30(c);
        d = (lt > lc) ? lt - lc : 0;
        return p * (d >> igbs_pkg::FRAC_BITS)
               + ((p * (d & ((64'd1 << igbs_pkg::FRAC_BITS) - 1))) >> igbs_pkg::FRAC_BITS);
    endfunction

    // Binary entropy with clamping of counts above the total
    function automatic longint unsigned set_entropy(longint unsigned y, longint unsigned n,
                                                   longint unsigned t, inout bit err);
        if (y > t) begin err = 1'b1; y = t; end
        if (n > t) begin err = 1'b1; n = t; end
        if (t == 0) return 0;
        return class_term(y, t) + class_term(n, t);
    endfunction

    // Update the node state with one accepted feature; queue the verdict on last
    function automatic void score_feature(t_feature f);
        bit err;
        longint unsigned hp, hl, hr, sub, g;
        logic signed [31:0] gain;
        err = 1'b0;
        sub = 0;
        gain = '0;
        hp = set_entropy(f.py, f.pn, f.pt, err);
        hl = set_entropy(f.ly, f.ln, f.lt, err);
        hr = set_entropy(f.ry, f.rn, f.rt, err);
        if (err) node_err = 1'b1;
        if (f.considered && f.fidx < igbs_pkg::MAX_FEATURES) begin
            if (f.pt != 0)
                sub = (64'(f.lt) * hl) / f.pt + (64'(f.rt) * hr) / f.pt;
            if (hp >= sub) begin
                g = hp - sub;
                gain = (g > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(g);
            end else begin
                g = sub - hp;
                gain = (g >= 64'h8000_0000) ? 32'sh8000_0000 : -$signed(32'(g));
            end
        end
        if (!node_seen || gain > node_best_gain) begin
            node_best_gain = gain;
            node_best_idx = f.fidx;
            node_seen = 1'b1;
        end
        if (f.last) begin
            verdict_q.push_back('{node_best_idx, node_best_gain, node_err});
            node_best_gain = '0;
            node_best_idx = '0;
            node_seen = 1'b0;
            node_err = 1'b0;
        end
    endfunction

    task automatic report_mismatch(string what, longint expv, longint gotv);
        n_fail++;
        $display("MISMATCH %s: expected %0d got %0d at %0t", what, expv, gotv, $realtime);
    endtask

    // Offer one request and wait for it to be taken
    task automatic send_feature(t_feature f);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, 9) : 0;
        @(negedge i_clk);
        if (gap > 0 && tx_started) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        tx_started = 1'b1;
        s_axis_tdata <= igbs_pkg::IN_DATA_W'({f.rt, f.rn, f.ry, f.lt, f.ln, f.ly,
                                              f.pt, f.pn, f.py, f.fidx});
        s_axis_tuser <= f.considered;
        s_axis_tlast <= f.last;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        score_feature(f);
    endtask

    // Build counts for one set of total t; consistent unless noisy
    function automatic void split_counts(int t, bit noisy, output logic [15:0] y,
                                         output logic [15:0] n);
        if (noisy) begin
            y = $urandom_range(0, 65535);
            n = $urandom_range(0, 65535);
        end else begin
            y = $urandom_range(0, t);
            n = t - y;
        end
    endfunction

    function automatic t_feature random_feature(bit last);
        t_feature f;
        bit noisy;
        int pt, lt, ly;
        noisy = ($urandom_range(0, 9) == 0);
        pt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 200);
        f.fidx = $urandom_range(0, 63);
        f.considered = ($urandom_range(0, 4) != 0);
        f.last = last;
        if (noisy) begin
            f.pt = $urandom_range(0, 65535);
            f.lt = $urandom_range(0, 65535);
            f.rt = $urandom_range(0, 65535);
            split_counts(0, 1'b1, f.py, f.pn);
            split_counts(0, 1'b1, f.ly, f.ln);
            split_counts(0, 1'b1, f.ry, f.rn);
        end else begin
            // Branches partition the parent rows and its classes
            f.pt = pt;
            split_counts(pt, 1'b0, f.py, f.pn);
            lt = $urandom_range(0, pt);
            ly = $urandom_range((lt > f.pn) ? lt - f.pn : 0, (lt < f.py) ? lt : f.py);
            f.lt = lt;
            f.ly = ly;
            f.ln = lt - ly;
            f.rt = pt - lt;
            f.ry = f.py - ly;
            f.rn = f.pn - f.ln;
        end
        return f;
    endfunction

    task automatic send_random_nodes(int n_items);
        int left, sz;
        left = n_items;
        while (left > 0) begin
            sz = $urandom_range(1, 8);
            if (sz > left) sz = left;
            for (int i = 0; i < sz; i++) send_feature(random_feature(i == sz - 1));
            left -= sz;
        end
    endtask

    // Hand-picked corner cases, fields listed fidx, cons, p, l, r, last
    task automatic test_corner_cases();
        t_feature f;
        // all zero, single-item node
        f = '{6'd0, 1'b1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1};
        send_feature(f);
        // full counts, perfect split then an ineligible feature
        f = '{6'd63, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 16'hFFFF,
              0, 16'hFFFF, 16'hFFFF, 1'b0};
        send_feature(f);
        f = '{6'd5, 1'b0, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h8000, 0, 16'h8000,
              0, 16'h7FFF, 16'h7FFF, 1'b1};
        send_feature(f);
        // perfect split of 4 rows, tie with the same split later: earliest wins
        f = '{6'd9, 1'b1, 2, 2, 4, 2, 0, 2, 0, 2, 2, 1'b0};
        send_feature(f);
        f = '{6'd10, 1'b1, 2, 2, 4, 2, 0, 2, 0, 2, 2, 1'b0};
        send_feature(f);
        // useless split, zero gain
        f = '{6'd11, 1'b1, 2, 2, 4, 1, 1, 2, 1, 1, 2, 1'b1};
        send_feature(f);
        // class count above total, on an ineligible item
        f = '{6'd1, 1'b0, 9, 1, 4, 0, 0, 0, 0, 0, 0, 1'b1};
        send_feature(f);
        // class count above total on branches
        f = '{6'd2, 1'b1, 3, 3, 6, 7, 0, 3, 0, 9, 3, 1'b1};
        send_feature(f);
        // empty parent with non-empty branches
        f = '{6'd3, 1'b1, 0, 0, 0, 5, 5, 10, 1, 1, 2, 1'b1};
        send_feature(f);
        // branch totals far above parent: negative gain, saturating
        f = '{6'd4, 1'b1, 1, 0, 1, 16'h7FFF, 16'h8000, 16'hFFFF,
              16'h8000, 16'h7FFF, 16'hFFFF, 1'b0};
        send_feature(f);
        f = '{6'd6, 1'b1, 1, 1, 2, 1, 1, 16'h8000, 1, 1, 2, 1'b1};
        send_feature(f);
        // one-row sets and alternating bit patterns
        f = '{6'd42, 1'b1, 16'hAAAA, 16'h5555, 16'hFFFF, 16'h5555, 16'h2AAA, 16'h7FFF,
              16'h5555, 16'h2AAB, 16'h8000, 1'b0};
        send_feature(f);
        f = '{6'd21, 1'b1, 1, 0, 1, 1, 0, 1, 0, 0, 0, 1'b1};
        send_feature(f);
    endtask

    task automatic test_random_traffic();
        send_random_nodes(N_RANDOM / 2);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        send_random_nodes(60);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        send_random_nodes(N_RANDOM / 2 - 100);
    endtask

    // Receiver holds off while single-item nodes keep coming
    task automatic test_backpressure();
        hold_go = 1'b1;
        for (int i = 0; i < 10; i++) send_feature(random_feature(1'b1));
        send_random_nodes(30);
    endtask

    // Output ready: long hold-off once, then a drawn gap after each result
    always @(negedge i_clk) begin
        int gap;
        if (hold_go && !hold_used) begin
            hold_used <= 1'b1;
            rx_hold <= HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_axis_tready <= 1'b0;
        end else if (n_taken != n_gapped) begin
            n_gapped <= n_taken;
            gap = rx_idle_en ? $urandom_range(0, 9) : 0;
            rx_gap <= (gap > 0) ? gap - 1 : 0;
            m_axis_tready <= (gap == 0);
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Result check
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_taken <= n_taken + 1;
            if (verdict_q.size() == 0) begin
                report_mismatch("unexpected result", 0, 1);
            end else begin
                t_verdict v;
                v = verdict_q.pop_front();
                if (m_axis_tdata[igbs_pkg::IDX_W-1:0] !== v.idx)
                    report_mismatch("best_index", v.idx,
                                    m_axis_tdata[igbs_pkg::IDX_W-1:0]);
                if (m_axis_tdata[igbs_pkg::IDX_W +: igbs_pkg::GAIN_W] !== v.gain)
                    report_mismatch("best_gain", $signed(v.gain),
                                    $signed(m_axis_tdata[igbs_pkg::IDX_W +: igbs_pkg::GAIN_W]));
                if (m_axis_tuser !== v.err)
                    report_mismatch("counts_error", v.err, m_axis_tuser);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_corner_cases();
        test_random_traffic();
        test_backpressure();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
design/igbs_pkg.sv
design/igbs_div.sv
design/igbs_seq.sv
design/info_gain_best_split_unit.sv
design/igbs_checker.sv
verif/tb_info_gain_best_split_unit.sv
